// File: hdl/kmd_pkg.sv
// Package with the shared constants of the k-way merge with duplicate removal.
`default_nettype none
package kmd_pkg;
    localparam int KEY_W      = 64;  // key width on the channels
    localparam int LANE_W     = 3;   // lane index width on the channels
    localparam int CNT_W      = 4;   // width of dup_count and of lanes_in_use
    localparam int MASK_W     = 8;   // width of refill_mask
    localparam int LANE_REACH = 8;   // lanes that the lane field can name
    localparam int ADDR_W     = 2;
    localparam int DATA_W     = 32;

    localparam logic [ADDR_W-1:0] ADDR_LANES_IN_USE = 2'd0;
    localparam logic [CNT_W-1:0]  LANES_RESET       = 4'd8;
endpackage
`default_nettype wire

// File: hdl/kmd_if.sv
// Valid/ready channel interfaces for input records and merge results.
`default_nettype none
interface kmd_in_if;
    logic                         valid;
    logic                         ready;
    logic [kmd_pkg::LANE_W-1:0]   lane;
    logic [kmd_pkg::KEY_W-1:0]    key;
    logic                         lane_end;

    modport source (output valid, lane, key, lane_end, input ready);
    modport sink   (input valid, lane, key, lane_end, output ready);
endinterface

interface kmd_out_if;
    logic                         valid;
    logic                         ready;
    logic [kmd_pkg::KEY_W-1:0]    key_res;
    logic [kmd_pkg::LANE_W-1:0]   source_lane;
    logic [kmd_pkg::CNT_W-1:0]    dup_count;
    logic [kmd_pkg::MASK_W-1:0]   refill_mask;
    logic                         done_res;

    modport source (output valid, key_res, source_lane, dup_count, refill_mask, done_res,
                    input ready);
    modport sink   (input valid, key_res, source_lane, dup_count, refill_mask, done_res,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/kmd_pick.sv
// Flat minimum search over the lane heads with lowest-lane tie break and match mask.
`default_nettype none
module kmd_pick #(
    parameter int ACT      = 8,
    parameter int KEY_BITS = 64
) (
    input  wire logic [ACT-1:0]               i_live,
    input  wire logic [ACT-1:0][KEY_BITS-1:0] i_keys,
    output logic                              o_any,
    output logic [KEY_BITS-1:0]               o_best,
    output logic [kmd_pkg::LANE_W-1:0]        o_src,
    output logic [ACT-1:0]                    o_eq
);
    logic [ACT-1:0]          win;
    logic [ACT-1:0][ACT-1:0] same;

    // Every pair is compared in parallel; a live head wins when it is below all
    // live heads of lower lanes and not above any live head of a higher lane.
    always_comb begin
        for (int i = 0; i < ACT; i++) begin
            win[i] = i_live[i];
            for (int j = 0; j < ACT; j++) begin
                same[i][j] = (i_keys[i] == i_keys[j]);
                if (j != i && i_live[j]) begin
                    if (j < i) begin
                        win[i] = win[i] & (i_keys[i] < i_keys[j]);
                    end else begin
                        win[i] = win[i] & (i_keys[i] <= i_keys[j]);
                    end
                end
            end
        end
    end

    always_comb begin
        o_any  = |i_live;
        o_best = '0;
        o_src  = '0;
        for (int i = 0; i < ACT; i++) begin
            if (win[i]) begin
                o_best = o_best | i_keys[i];
                o_src  = o_src | kmd_pkg::LANE_W'(i);
            end
        end
        for (int i = 0; i < ACT; i++) begin
            o_eq[i] = 1'b0;
            for (int j = 0; j < ACT; j++) begin
                o_eq[i] = o_eq[i] | (win[j] & same[i][j]);
            end
            o_eq[i] = o_eq[i] & i_live[i];
        end
    end
endmodule
`default_nettype wire

// File: hdl/kway_merge_dedup.sv
// Top level: K-way merge of sorted key lanes with duplicate removal.
// Flow: a request is registered at acceptance and processed once the output register
// is empty or being read; its result, if any, is written to the output register as it is processed.
// Throughput: one request per cycle unless the output stalls; set by the head update and compare loop.
// Reset clears head valid bits, lane finished bits, the done flag and the valid bits of both
// channel registers, and sets lanes_in_use to 8; head keys are not cleared.
`default_nettype none
module kway_merge_dedup #(
    parameter int LANES    = 8,
    parameter int KEY_BITS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    kmd_in_if.sink                              i_in,
    kmd_out_if.source                           o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [kmd_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [kmd_pkg::DATA_W-1:0]     pwdata,
    output logic      [kmd_pkg::DATA_W-1:0]     prdata,
    output logic                                pready
);
    localparam int ACT = (LANES < kmd_pkg::LANE_REACH) ? LANES : kmd_pkg::LANE_REACH;
    localparam logic [kmd_pkg::CNT_W-1:0] ACT_N = kmd_pkg::CNT_W'(ACT);

    // Configuration register
    logic [kmd_pkg::CNT_W-1:0] r_lanes;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr == kmd_pkg::ADDR_LANES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes <= kmd_pkg::LANES_RESET;
        end else if (cfg_wr) begin
            r_lanes <= pwdata[kmd_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == kmd_pkg::ADDR_LANES_IN_USE) begin
            prdata = kmd_pkg::DATA_W'(r_lanes);
        end
    end

    // Input register
    logic                        r_in_valid;
    logic [kmd_pkg::LANE_W-1:0]  r_lane;
    logic [KEY_BITS-1:0]         r_key;
    logic                        r_end;
    logic                        proc;

    assign proc       = r_in_valid & (~o_out.valid | o_out.ready);
    assign i_in.ready = ~r_in_valid | proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_lane <= i_in.lane;
            r_key  <= i_in.key[KEY_BITS-1:0];
            r_end  <= i_in.lane_end;
        end
    end

    // Lane state
    logic [ACT-1:0][KEY_BITS-1:0] r_head_key;
    logic [ACT-1:0]               r_head_valid;
    logic [ACT-1:0]               r_fin;
    logic                         r_done_sent;

    logic [kmd_pkg::CNT_W-1:0]    n_act;
    logic [ACT-1:0]               act;
    logic [ACT-1:0][KEY_BITS-1:0] n_head_key;
    logic [ACT-1:0]               upd_valid;
    logic [ACT-1:0]               n_fin;
    logic [ACT-1:0]               live;
    logic                         all_ready;

    always_comb begin
        n_act = r_lanes;
        if (n_act == '0) begin
            n_act = 4'd1;
        end
        if (n_act > ACT_N) begin
            n_act = ACT_N;
        end
        for (int i = 0; i < ACT; i++) begin
            act[i]        = (kmd_pkg::CNT_W'(i) < n_act);
            n_head_key[i] = r_head_key[i];
            upd_valid[i]  = r_head_valid[i];
            n_fin[i]      = r_fin[i];
            if (act[i] && r_lane == kmd_pkg::LANE_W'(i)) begin
                if (r_end) begin
                    n_fin[i] = 1'b1;
                end else if (!r_head_valid[i] && !r_fin[i]) begin
                    n_head_key[i] = r_key;
                    upd_valid[i]  = 1'b1;
                end
            end
        end
        live      = act & upd_valid;
        all_ready = &(~act | upd_valid | n_fin);
    end

    logic                        any;
    logic [KEY_BITS-1:0]         best;
    logic [kmd_pkg::LANE_W-1:0]  src;
    logic [ACT-1:0]              eq;

    kmd_pick #(
        .ACT      (ACT),
        .KEY_BITS (KEY_BITS)
    ) u_pick (
        .i_live (live),
        .i_keys (n_head_key),
        .o_any  (any),
        .o_best (best),
        .o_src  (src),
        .o_eq   (eq)
    );

    logic                        emit_key;
    logic                        emit_done;
    logic [kmd_pkg::CNT_W-1:0]   cnt;
    logic [kmd_pkg::MASK_W-1:0]  refill;

    always_comb begin
        emit_key  = all_ready & any;
        emit_done = all_ready & ~any & ~r_done_sent;
        cnt       = '0;
        refill    = '0;
        for (int i = 0; i < ACT; i++) begin
            cnt       = cnt + kmd_pkg::CNT_W'(eq[i]);
            refill[i] = eq[i] & ~n_fin[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_fin        <= '0;
            r_done_sent  <= 1'b0;
        end else if (proc) begin
            r_head_valid <= emit_key ? (upd_valid & ~eq) : upd_valid;
            r_fin        <= n_fin;
            if (emit_done) begin
                r_done_sent <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_head_key <= n_head_key;
        end
    end

    // Output register
    logic                        r_out_valid;
    logic [kmd_pkg::KEY_W-1:0]   r_key_res;
    logic [kmd_pkg::LANE_W-1:0]  r_src;
    logic [kmd_pkg::CNT_W-1:0]   r_cnt;
    logic [kmd_pkg::MASK_W-1:0]  r_refill;
    logic                        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && (emit_key || emit_done)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && (emit_key || emit_done)) begin
            r_key_res <= emit_key ? kmd_pkg::KEY_W'(best) : '0;
            r_src     <= emit_key ? src : '0;
            r_cnt     <= emit_key ? cnt : '0;
            r_refill  <= emit_key ? refill : '0;
            r_done    <= emit_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.key_res     = r_key_res;
    assign o_out.source_lane = r_src;
    assign o_out.dup_count   = r_cnt;
    assign o_out.refill_mask = r_refill;
    assign o_out.done_res    = r_done;

    // Checks
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res) |->
        (o_out.key_res == '0 && o_out.dup_count == '0 && o_out.refill_mask == '0))
        else $error("done result carries a key payload");

    a_key_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.done_res) |->
        (o_out.dup_count != '0 && $countones(o_out.refill_mask) <= o_out.dup_count))
        else $error("key result consumed no head or refills more lanes than consumed");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done_sent) |-> (o_out.valid && o_out.done_res))
        else $error("done flag set without a done result");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done_sent && o_out.valid && o_out.done_res && proc) |=>
        !(o_out.valid && o_out.done_res && !$past(o_out.ready)) || $stable(r_done_sent))
        else $error("done flag changed after done was reported");
endmodule
`default_nettype wire
